>>> hw/rtl/r10u_pkg.sv
// Package for the RAW10 frame unpacker: limits, register indexes and size helpers.
package r10u_pkg;

   localparam int MAX_LINE_PIXELS = 4096;
   localparam int MAX_LINES       = 4096;
   localparam int META_LINES_MAX  = 4;
   localparam int ALIGN_LOG2_MAX  = 8;
   localparam int GROUP_BYTES     = 5;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int LEN_W       = 13;   // line lengths, positions and line counts
   localparam int COUNT_W     = 25;   // bytes in a frame
   localparam int PIXEL_W     = 10;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 48;

   localparam logic [LEN_W-1:0] PPL_RESET   = LEN_W'(640);
   localparam logic [LEN_W-1:0] LINES_RESET = LEN_W'(480);
   localparam logic [2:0]       META_RESET  = 3'd1;
   localparam logic [3:0]       ALIGN_RESET = 4'd1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_UNPACK_MODE,
      CSR_PIXELS_PER_LINE,
      CSR_IMAGE_LINES,
      CSR_METADATA_LINES,
      CSR_ALIGN_LOG2
   } csr_index_type;

   typedef enum logic {
      MODE_LSB_FIRST = 1'b0,
      MODE_MIPI      = 1'b1
   } unpack_mode_type;

   // Bytes of pixel data in one line: width clamped to 4..MAX_LINE_PIXELS, whole groups.
   function automatic logic [LEN_W-1:0] line_stride(input logic [LEN_W-1:0] ppl);
      logic [LEN_W-1:0] px;
      logic [LEN_W-3:0] groups;
      px = {ppl[LEN_W-1:2], 2'b00};
      if (px < LEN_W'(4)) px = LEN_W'(4);
      if (px > LEN_W'(MAX_LINE_PIXELS)) px = LEN_W'(MAX_LINE_PIXELS);
      groups = px[LEN_W-1:2];
      return {groups, 2'b00} + LEN_W'(groups);
   endfunction

   // Line length rounded up to the alignment, exponent clamped to 1..ALIGN_LOG2_MAX.
   function automatic logic [LEN_W-1:0] padded_len(input logic [LEN_W-1:0] stride,
                                                   input logic [3:0] align);
      logic [3:0]       a;
      logic [LEN_W-1:0] mask;
      a = align;
      if (a < 4'd1) a = 4'd1;
      if (a > 4'(ALIGN_LOG2_MAX)) a = 4'(ALIGN_LOG2_MAX);
      mask = (LEN_W'(1) << a) - LEN_W'(1);
      return (stride + mask) & ~mask;
   endfunction

   function automatic logic [2:0] eff_meta(input logic [2:0] meta);
      return (meta > 3'(META_LINES_MAX)) ? 3'(META_LINES_MAX) : meta;
   endfunction

   function automatic logic [LEN_W-1:0] eff_lines(input logic [LEN_W-1:0] lines);
      logic [LEN_W-1:0] n;
      n = lines;
      if (n < LEN_W'(1)) n = LEN_W'(1);
      if (n > LEN_W'(MAX_LINES)) n = LEN_W'(MAX_LINES);
      return n;
   endfunction

endpackage

>>> hw/rtl/raw10_frame_unpacker.sv
// RAW10 frame unpacker: skips metadata lines and padding, emits four-pixel groups and frame status.
//
//   channel   dir   transaction
//   req_      in    one frame byte (tuser 0) or end of frame (tuser 1)
//   rsp_      out   one pixel group (tuser 0) or frame status (tuser 1)
//   csr_      in    register write, index in csr_addr, no read-back
//
// One byte per cycle while the result is not stalled; an input register and a result
// register, with all per-byte work between them, stand between accept and result.
// The frame size compare uses a product registered from the registered sizes, so it lags them.
// Reset is synchronous and restores the register defaults and clears all counters.
// A result waiting on rsp_tready holds one more item in the input register; after that
// req_tready drops until the result is taken.
module raw10_frame_unpacker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [r10u_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] data_byte
   input  logic                               req_tuser,   // [0] kind
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [9:0] pixel_a, [19:10] pixel_b, [29:20] pixel_c, [39:30] pixel_d, [40] frame_ok
   output logic [r10u_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,   // line_end
   output logic                               rsp_tuser,   // [0] result_kind
   input  logic                               csr_we,
   input  logic [r10u_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [r10u_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import r10u_pkg::*;

   // Configuration registers and the sizes derived from them.
   logic             mode_ff,  mode_in;
   logic [LEN_W-1:0] ppl_ff,   ppl_in;
   logic [LEN_W-1:0] lines_ff, lines_in;
   logic [2:0]       meta_ff,  meta_in;
   logic [3:0]       align_ff, align_in;

   logic [LEN_W-1:0]   stride_ff;
   logic [LEN_W-1:0]   padded_ff;
   logic [2:0]         meta_lines_ff;
   logic [LEN_W-1:0]   total_lines_ff;
   logic [COUNT_W-1:0] packet_ff;

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   logic                  in_kind_ff;
   logic [REQ_DATA_W-1:0] in_byte_ff;

   // Frame state.
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]   pos_ff,   pos_in;
   logic [LEN_W-1:0]   line_ff,  line_in;
   logic [2:0]         grp_ff,   grp_in;
   logic [3:0][7:0]    held_ff,  held_in;
   logic               ovf_ff,   ovf_in;

   // Result register.
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  out_last_ff;
   logic                  out_kind_ff;

   logic                  advance;
   logic                  res_valid;
   logic                  res_kind;
   logic                  res_last;
   logic                  res_ok;
   logic [PIXEL_W-1:0]    p0, p1, p2, p3;
   logic [7:0]            b4;
   logic [LEN_W:0]        pos_inc;
   logic                  in_image;

   // ---------------- configuration ----------------
   always_comb begin
      mode_in  = mode_ff;
      ppl_in   = ppl_ff;
      lines_in = lines_ff;
      meta_in  = meta_ff;
      align_in = align_ff;
      if (reset) begin
         mode_in  = MODE_LSB_FIRST;
         ppl_in   = PPL_RESET;
         lines_in = LINES_RESET;
         meta_in  = META_RESET;
         align_in = ALIGN_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_UNPACK_MODE:     mode_in  = csr_wdata[0];
            CSR_PIXELS_PER_LINE: ppl_in   = csr_wdata[LEN_W-1:0];
            CSR_IMAGE_LINES:     lines_in = csr_wdata[LEN_W-1:0];
            CSR_METADATA_LINES:  meta_in  = csr_wdata[2:0];
            CSR_ALIGN_LOG2:      align_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // The sizes follow the next register values, so they are current at the write edge;
   // the frame size product is registered from those sizes and so lags behind them.
   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      ppl_ff         <= ppl_in;
      lines_ff       <= lines_in;
      meta_ff        <= meta_in;
      align_ff       <= align_in;
      stride_ff      <= line_stride(ppl_in);
      padded_ff      <= padded_len(line_stride(ppl_in), align_in);
      meta_lines_ff  <= eff_meta(meta_in);
      total_lines_ff <= LEN_W'(eff_meta(meta_in)) + eff_lines(lines_in);
      packet_ff      <= COUNT_W'(padded_ff) * COUNT_W'(total_lines_ff);
   end

   // ---------------- input register ----------------
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // ---------------- per-byte work ----------------
   assign b4 = in_byte_ff;

   always_comb begin
      if (mode_ff == MODE_MIPI) begin
         p0 = {held_ff[0], b4[1:0]};
         p1 = {held_ff[1], b4[3:2]};
         p2 = {held_ff[2], b4[5:4]};
         p3 = {held_ff[3], b4[7:6]};
      end else begin
         p0 = {held_ff[1][1:0], held_ff[0]};
         p1 = {held_ff[2][3:0], held_ff[1][7:2]};
         p2 = {held_ff[3][5:0], held_ff[2][7:4]};
         p3 = {b4, held_ff[3][7:6]};
      end
   end

   assign in_image = (line_ff >= LEN_W'(meta_lines_ff)) && (line_ff < total_lines_ff)
                     && (pos_ff < stride_ff);
   assign pos_inc  = {1'b0, pos_ff} + (LEN_W+1)'(1);

   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      line_in   = line_ff;
      grp_in    = grp_ff;
      held_in   = held_ff;
      ovf_in    = ovf_ff;
      res_valid = 1'b0;
      res_kind  = 1'b0;
      res_last  = 1'b0;
      res_ok    = 1'b0;
      if (advance) begin
         if (in_kind_ff) begin
            res_valid = 1'b1;
            res_kind  = 1'b1;
            res_ok    = (count_ff == packet_ff) && !ovf_ff;
            count_in  = '0;
            pos_in    = '0;
            line_in   = '0;
            grp_in    = '0;
            held_in   = '0;
            ovf_in    = 1'b0;
         end else if (count_ff > packet_ff) begin
            // The store already holds one byte more than the frame; drop and restart.
            ovf_in   = 1'b1;
            count_in = '0;
            pos_in   = '0;
            line_in  = '0;
            grp_in   = '0;
            held_in  = '0;
         end else begin
            count_in = count_ff + COUNT_W'(1);
            if (in_image) begin
               if (!grp_ff[2]) begin
                  held_in[grp_ff[1:0]] = in_byte_ff;
                  grp_in = grp_ff + 3'd1;
               end else begin
                  res_valid = 1'b1;
                  res_last  = (pos_inc == {1'b0, stride_ff});
                  grp_in    = '0;
                  held_in   = '0;
               end
            end
            if (pos_inc >= {1'b0, padded_ff}) begin
               pos_in  = '0;
               grp_in  = '0;
               held_in = '0;
               if (line_ff < total_lines_ff) line_in = line_ff + LEN_W'(1);
            end else begin
               pos_in = pos_inc[LEN_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
         line_ff  <= '0;
         grp_ff   <= '0;
         held_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         grp_ff   <= grp_in;
         held_ff  <= held_in;
         ovf_ff   <= ovf_in;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) out_valid_in = 1'b0;
      if (res_valid) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (res_valid) begin
         out_kind_ff <= res_kind;
         out_last_ff <= res_last;
         if (res_kind) begin
            out_data_ff <= {{(RSP_DATA_W-4*PIXEL_W-1){1'b0}}, res_ok, {(4*PIXEL_W){1'b0}}};
         end else begin
            out_data_ff <= {{(RSP_DATA_W-4*PIXEL_W){1'b0}}, p3, p2, p1, p0};
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_kind_ff;

`ifndef SYNTHESIS
   // The group counter never runs past the fifth byte of a group.
   a_grp_range: assert property (@(posedge clock) disable iff (reset)
      grp_ff <= 3'd4)
      else $error("group position out of range");

   // A frame status carries no pixels and no line end.
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[4*PIXEL_W-1:0] == '0) && !rsp_tlast)
      else $error("frame status carries pixel data");

   // Back pressure only comes from a full input register behind a stalled result.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without a stalled result");

   // A byte that overflows the frame leaves all positions at zero.
   a_ovf_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_kind_ff && count_ff > packet_ff) |=>
         (ovf_ff && count_ff == '0 && pos_ff == '0 && line_ff == '0))
      else $error("overflow did not restart the frame");
`endif

endmodule

>>> sim/raw10_unpacker_check_pkg.sv
// Scoreboard for the RAW10 frame unpacker test: frame geometry, pixel prediction and checks.
`timescale 1ns / 1ps
package raw10_unpacker_check_pkg;
   import r10u_pkg::*;

   typedef enum logic {
      ITEM_BYTE         = 1'b0,
      ITEM_END_OF_FRAME = 1'b1
   } item_kind_type;

   typedef enum logic {
      RESULT_PIXELS = 1'b0,
      RESULT_STATUS = 1'b1
   } result_kind_type;

   typedef struct packed {
      result_kind_type    kind;
      logic [PIXEL_W-1:0] pixel_a;
      logic [PIXEL_W-1:0] pixel_b;
      logic [PIXEL_W-1:0] pixel_c;
      logic [PIXEL_W-1:0] pixel_d;
      logic               line_end;
      logic               frame_ok;
   } unpacked_result_type;

   class unpacker_scoreboard;
      unpack_mode_type     mode;
      logic [LEN_W-1:0]    width_reg;
      logic [LEN_W-1:0]    lines_reg;
      logic [2:0]          meta_reg;
      logic [3:0]          align_reg;

      logic [COUNT_W-1:0]  byte_count;
      logic [LEN_W-1:0]    line_pos;
      logic [LEN_W-1:0]    line_no;
      logic [2:0]          group_pos;
      logic [31:0]         held;
      logic                overflow;

      unpacked_result_type expected_q[$];
      int                  errors;

      function new();
         mode      = MODE_LSB_FIRST;
         width_reg = PPL_RESET;
         lines_reg = LINES_RESET;
         meta_reg  = META_RESET;
         align_reg = ALIGN_RESET;
         clear_frame();
         overflow  = 1'b0;
         errors    = 0;
      endfunction

      function void clear_frame();
         byte_count = '0;
         line_pos   = '0;
         line_no    = '0;
         group_pos  = '0;
         held       = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_UNPACK_MODE:     mode = unpack_mode_type'(value[0]);
            CSR_PIXELS_PER_LINE: width_reg = value;
            CSR_IMAGE_LINES:     lines_reg = value;
            CSR_METADATA_LINES:  meta_reg = value[2:0];
            CSR_ALIGN_LOG2:      align_reg = value[3:0];
            default: ;
         endcase
      endfunction

      // Pixel bytes of one line; the width is cut to whole groups of four and clamped.
      function int unsigned line_data_bytes();
         int unsigned px;
         px = 32'({width_reg[LEN_W-1:2], 2'b00});
         if (px < 4) px = 4;
         if (px > MAX_LINE_PIXELS) px = MAX_LINE_PIXELS;
         return (px / 4) * GROUP_BYTES;
      endfunction

      function int unsigned line_padded_bytes();
         int unsigned a;
         int unsigned step;
         a = 32'(align_reg);
         if (a < 1) a = 1;
         if (a > ALIGN_LOG2_MAX) a = ALIGN_LOG2_MAX;
         step = 1 << a;
         return (line_data_bytes() + step - 1) & ~(step - 1);
      endfunction

      function int unsigned meta_count();
         return (meta_reg > META_LINES_MAX) ? META_LINES_MAX : meta_reg;
      endfunction

      function int unsigned image_count();
         int unsigned n;
         n = 32'(lines_reg);
         if (n < 1) n = 1;
         if (n > MAX_LINES) n = MAX_LINES;
         return n;
      endfunction

      function int unsigned frame_bytes();
         return line_padded_bytes() * (meta_count() + image_count());
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Called for every accepted input transaction.
      function void unpack_item(item_kind_type kind, logic [7:0] data);
         int unsigned         stride;
         int unsigned         padded;
         int unsigned         meta_n;
         int unsigned         total;
         int unsigned         frame_len;
         int unsigned         pos;
         logic [7:0]          b0;
         logic [7:0]          b1;
         logic [7:0]          b2;
         logic [7:0]          b3;
         unpacked_result_type r;
         stride    = line_data_bytes();
         padded    = line_padded_bytes();
         meta_n    = meta_count();
         total     = meta_n + image_count();
         frame_len = padded * total;
         r         = '0;
         if (kind == ITEM_END_OF_FRAME) begin
            r.kind     = RESULT_STATUS;
            r.frame_ok = (byte_count == frame_len) && !overflow;
            expected_q.push_back(r);
            clear_frame();
            overflow = 1'b0;
            return;
         end
         // The byte store holds one byte more than the frame; past that the byte is lost
         // and counting starts over.
         if (byte_count >= frame_len + 1) begin
            overflow = 1'b1;
            clear_frame();
            return;
         end
         byte_count++;
         if (line_no >= meta_n && line_no < total && line_pos < stride) begin
            if (group_pos < 4) begin
               held = held | (32'(data) << (8 * group_pos));
               group_pos++;
            end else begin
               {b3, b2, b1, b0} = held;
               r.kind = RESULT_PIXELS;
               if (mode == MODE_MIPI) begin
                  r.pixel_a = {b0, data[1:0]};
                  r.pixel_b = {b1, data[3:2]};
                  r.pixel_c = {b2, data[5:4]};
                  r.pixel_d = {b3, data[7:6]};
               end else begin
                  r.pixel_a = {b1[1:0], b0};
                  r.pixel_b = {b2[3:0], b1[7:2]};
                  r.pixel_c = {b3[5:0], b2[7:4]};
                  r.pixel_d = {data, b3[7:6]};
               end
               r.line_end = (line_pos + 1 == stride);
               expected_q.push_back(r);
               group_pos = '0;
               held      = '0;
            end
         end
         pos = line_pos + 1;
         if (pos >= padded) begin
            pos       = 0;
            group_pos = '0;
            held      = '0;
            if (line_no < total) line_no++;
         end
         line_pos = LEN_W'(pos);
      endfunction

      function void check_field(string name, logic [PIXEL_W-1:0] want,
                                logic [PIXEL_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      // Called for every accepted result transaction.
      function void compare_result(logic [RSP_DATA_W-1:0] data, logic last, logic user);
         unpacked_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: result expected none actual tuser %0h tlast %0h tdata %h",
                     $time, user, last, data);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         check_field("result_kind", PIXEL_W'(want.kind), PIXEL_W'(user));
         check_field("pixel_a", want.pixel_a, data[9:0]);
         check_field("pixel_b", want.pixel_b, data[19:10]);
         check_field("pixel_c", want.pixel_c, data[29:20]);
         check_field("pixel_d", want.pixel_d, data[39:30]);
         check_field("frame_ok", PIXEL_W'(want.frame_ok), PIXEL_W'(data[40]));
         check_field("tdata spare bits", '0, PIXEL_W'(data[RSP_DATA_W-1:41]));
         check_field("line_end", PIXEL_W'(want.line_end), PIXEL_W'(last));
      endfunction
   endclass

endpackage

>>> sim/raw10_frame_unpacker_test.sv
// Testbench top for the RAW10 frame unpacker: directed and random frames under varied flow control.
`timescale 1ns / 1ps
module raw10_frame_unpacker_test;
   import r10u_pkg::*;
   import raw10_unpacker_check_pkg::*;

   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 8;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int items_sent         = 0;
   int cycle_count        = 0;

   unpacker_scoreboard sb;

   raw10_frame_unpacker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.unpack_item(item_kind_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) sb.compare_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("raw10_frame_unpacker: mismatch");
      $finish;
   end

   // Valid stays high from one transaction to the next unless an idle gap is drawn.
   task automatic send_item(input item_kind_type kind, input logic [7:0] data);
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_results();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // Bytes that give no result may still be in flight after the last result, so the
   // task waits before the writes and again after them.
   task automatic apply_setting(input unpack_mode_type mode, input logic [LEN_W-1:0] width,
                                input logic [LEN_W-1:0] lines, input logic [2:0] meta,
                                input logic [3:0] align);
      stop_sending();
      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      write_csr(CSR_UNPACK_MODE, CSR_DATA_W'(mode));
      write_csr(CSR_PIXELS_PER_LINE, width);
      write_csr(CSR_IMAGE_LINES, lines);
      write_csr(CSR_METADATA_LINES, CSR_DATA_W'(meta));
      write_csr(CSR_ALIGN_LOG2, CSR_DATA_W'(align));
      csr_we <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // Mostly whole frames; some short, some long enough to overflow, some empty.
   // Frames too large for the run are cut short.
   task automatic send_frame(input bit with_end);
      int unsigned len;
      int unsigned choice;
      len    = sb.frame_bytes();
      choice = $urandom_range(0, 99);
      if (len > 600) len = $urandom_range(20, 200);
      else if (choice < 15) len = $urandom_range(0, len - 1);
      else if (choice < 25) len = len + $urandom_range(1, 3);
      else if (choice < 28) len = 0;
      for (int i = 0; i < len; i++) send_item(ITEM_BYTE, 8'($urandom_range(0, 255)));
      if (with_end) send_item(ITEM_END_OF_FRAME, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      unpack_mode_type  mode;
      logic [LEN_W-1:0] width;
      logic [LEN_W-1:0] lines;
      logic [2:0]       meta;
      logic [3:0]       align;
      int               phase;
      int               frames;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Two one-group lines: all ones, then all zeros, each followed by a pad byte.
      apply_setting(MODE_LSB_FIRST, 13'd4, 13'd2, 3'd0, 4'd1);
      repeat (5) send_item(ITEM_BYTE, 8'hFF);
      send_item(ITEM_BYTE, 8'h00);
      repeat (5) send_item(ITEM_BYTE, 8'h00);
      send_item(ITEM_BYTE, 8'hFF);
      send_item(ITEM_END_OF_FRAME, 8'h00);

      // One line in the MIPI layout, a byte past the frame, then one that overflows.
      apply_setting(MODE_MIPI, 13'd4, 13'd1, 3'd0, 4'd1);
      send_item(ITEM_BYTE, 8'h12);
      send_item(ITEM_BYTE, 8'h34);
      send_item(ITEM_BYTE, 8'h56);
      send_item(ITEM_BYTE, 8'h78);
      send_item(ITEM_BYTE, 8'hE4);
      send_item(ITEM_BYTE, 8'hAA);
      send_item(ITEM_BYTE, 8'h55);
      send_item(ITEM_BYTE, 8'h0F);
      send_item(ITEM_END_OF_FRAME, 8'hFF);
      send_item(ITEM_END_OF_FRAME, 8'h00);

      items_sent = 0;
      phase      = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case (phase)
            0: begin
               mode = MODE_MIPI; width = 13'd4096; lines = 13'd4096; meta = 3'd0; align = 4'd8;
            end
            1: begin
               mode = MODE_LSB_FIRST; width = 13'd4; lines = 13'd1; meta = 3'd4; align = 4'd1;
            end
            2: begin
               mode = MODE_MIPI; width = '1; lines = '1; meta = '1; align = '1;
            end
            3: begin
               mode = MODE_LSB_FIRST; width = '0; lines = '0; meta = '0; align = '0;
            end
            default: begin
               mode  = unpack_mode_type'(1'($urandom_range(0, 1)));
               width = LEN_W'($urandom_range(1, 3) * 4);
               if ($urandom_range(0, 3) == 0) width = width | LEN_W'($urandom_range(0, 3));
               lines = LEN_W'($urandom_range(1, 3));
               meta  = 3'($urandom_range(0, 7));
               align = 4'($urandom_range(1, 4));
               case ($urandom_range(0, 19))
                  0: width = LEN_W'($urandom_range(0, 3));
                  1: width = LEN_W'($urandom_range(MAX_LINE_PIXELS, 8191));
                  2: lines = '0;
                  3: lines = LEN_W'($urandom_range(MAX_LINES, 8191));
                  4: align = 4'($urandom_range(ALIGN_LOG2_MAX, 15));
                  5: align = '0;
                  default: ;
               endcase
            end
         endcase
         apply_setting(mode, width, lines, meta, align);

         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
            default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         endcase

         frames = $urandom_range(2, 5);
         repeat (frames) begin
            send_frame(1'b1);
            if (phase == 1 || $urandom_range(0, 7) == 0) begin
               stop_sending();
               wait_for_results();
            end
         end
         // Leaving a frame open makes the next register writes land mid-frame.
         if ($urandom_range(0, 3) == 0) send_frame(1'b0);
         phase++;
      end

      stop_sending();
      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0) begin
         $display("raw10_frame_unpacker: match");
      end else begin
         $display("raw10_frame_unpacker: mismatch");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/r10u_pkg.sv
hw/rtl/raw10_frame_unpacker.sv
sim/raw10_unpacker_check_pkg.sv
sim/raw10_frame_unpacker_test.sv
